// ===== sv/osh_pkg.sv =====
// Package for the occurrence sample histogram.
// Holds the payload and configuration structs, operation and register codes, and FSM states.
// No dependencies.
`default_nettype none

package osh_pkg;

  localparam int IDX_W    = 10;
  localparam int HITS_W   = 16;
  localparam int UNIQ_W   = 11;
  localparam int OFF_W    = 32;
  localparam int SCNT_W   = 11;
  localparam int CFG_W    = 32;
  localparam int CFG_IX_W = 2;

  localparam logic [HITS_W-1:0] HIT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_OFFSET = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_SAMPLE_COUNT     = 2'd0,
    REG_STREAM_LENGTH    = 2'd1,
    REG_REPEAT_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] table_index;
    logic [OFF_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  sample_index;
    logic [HITS_W-1:0] sample_hits;
    logic              above_threshold;
    logic [UNIQ_W-1:0] unique_samples;
    logic              out_of_range;
  } out_t;

  typedef struct packed {
    logic [SCNT_W-1:0] sample_count;
    logic [OFF_W-1:0]  stream_length;
    logic [HITS_W-1:0] repeat_threshold;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAST,
    ST_CACHE_LO,
    ST_CACHE_HI,
    ST_SEARCH,
    ST_COUNT,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/osh_ram.sv =====
// Single-port synchronous RAM with registered read data.
// Read data updates only on a read; used for the boundary table and the hit counts.
// No dependencies.
`default_nettype none

module osh_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/osh_ctrl.sv =====
// Sequencer for the occurrence sample histogram: sample lookup (last-sample test,
// cache check, binary search), saturating count update, read, clear sweep.
// Depends on osh_pkg; drives the two osh_ram instances in the top level.
`default_nettype none

module osh_ctrl
  import osh_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cfg_t                           cfg,
  input  wire logic                           cfg_inval,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire in_t                            in_data,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output out_t                                res_data,
  output logic                                bnd_re,
  output logic                                bnd_we,
  output logic [$clog2(MAX_SAMPLES)-1:0]      bnd_addr,
  output logic [OFF_W-1:0]                    bnd_wdata,
  input  wire logic [OFF_W-1:0]               bnd_rdata,
  output logic                                cnt_re,
  output logic                                cnt_we,
  output logic [$clog2(MAX_SAMPLES)-1:0]      cnt_addr,
  output logic [HITS_W-1:0]                   cnt_wdata,
  input  wire logic [HITS_W-1:0]              cnt_rdata
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int DW = $clog2(MAX_SAMPLES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SAMPLES - 1);

  state_t          state_r, state_nxt;
  in_t             item_r, item_nxt;
  logic [AW-1:0]   lo_r, lo_nxt;
  logic [AW-1:0]   hi_r, hi_nxt;
  logic [AW-1:0]   mid_r, mid_nxt;
  logic [AW-1:0]   sidx_r, sidx_nxt;
  logic [AW-1:0]   clr_idx_r, clr_idx_nxt;
  logic            clr_op_r, clr_op_nxt;
  logic [AW-1:0]   cached_r, cached_nxt;
  logic            cache_v_r, cache_v_nxt;
  logic [DW-1:0]   distinct_r, distinct_nxt;
  out_t            res_r, res_nxt;

  logic [31:0]     sc32;
  logic [AW-1:0]   last_idx;

  // samples in use, clamped to 1..MAX_SAMPLES, minus one
  always_comb begin
    sc32 = 32'(cfg.sample_count);
    if (sc32 == 32'd0) begin
      last_idx = '0;
    end else if (sc32 > 32'(MAX_SAMPLES)) begin
      last_idx = LAST_ADDR;
    end else begin
      last_idx = AW'(sc32 - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_idx_r  <= '0;
      clr_op_r   <= 1'b0;
      cached_r   <= '0;
      cache_v_r  <= 1'b0;
      distinct_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_op_r   <= clr_op_nxt;
      cached_r   <= cached_nxt;
      cache_v_r  <= cache_v_nxt;
      distinct_r <= distinct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    sidx_r <= sidx_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    logic              found;
    logic [AW-1:0]     found_idx;
    logic              start_srch;
    logic [AW-1:0]     lo_n;
    logic [AW-1:0]     hi_n;
    logic [AW:0]       sum;
    logic              idx_ok;
    logic [HITS_W-1:0] hits;

    state_nxt    = state_r;
    item_nxt     = item_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    sidx_nxt     = sidx_r;
    clr_idx_nxt  = clr_idx_r;
    clr_op_nxt   = clr_op_r;
    cached_nxt   = cached_r;
    cache_v_nxt  = cache_v_r;
    distinct_nxt = distinct_r;
    res_nxt      = res_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    bnd_re    = 1'b0;
    bnd_we    = 1'b0;
    bnd_addr  = '0;
    bnd_wdata = in_data.value;
    cnt_re    = 1'b0;
    cnt_we    = 1'b0;
    cnt_addr  = '0;
    cnt_wdata = '0;

    found      = 1'b0;
    found_idx  = '0;
    start_srch = 1'b0;
    lo_n       = lo_r;
    hi_n       = hi_r;
    sum        = '0;
    hits       = '0;
    idx_ok     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        cnt_we   = 1'b1;
        cnt_addr = clr_idx_r;
        if (clr_idx_r == LAST_ADDR) begin
          clr_idx_nxt = '0;
          state_nxt   = clr_op_r ? ST_EMIT : ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          idx_ok   = 32'(in_data.table_index) < 32'(MAX_SAMPLES);
          res_nxt  = '0;
          case (in_data.operation)
            OP_LOAD: begin
              bnd_we               = idx_ok;
              bnd_addr             = AW'(in_data.table_index);
              cache_v_nxt          = 1'b0;
              res_nxt.sample_index = in_data.table_index;
              state_nxt            = ST_EMIT;
            end
            OP_CLEAR: begin
              clr_idx_nxt  = '0;
              clr_op_nxt   = 1'b1;
              cached_nxt   = '0;
              cache_v_nxt  = 1'b0;
              distinct_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            OP_OFFSET: begin
              if (in_data.value > cfg.stream_length) begin
                res_nxt.out_of_range = 1'b1;
                state_nxt            = ST_EMIT;
              end else begin
                bnd_re    = 1'b1;
                bnd_addr  = last_idx;
                state_nxt = ST_LAST;
              end
            end
            OP_READ: begin
              cnt_re    = idx_ok;
              cnt_addr  = AW'(in_data.table_index);
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_LAST: begin
        if (item_r.value >= bnd_rdata) begin
          found     = 1'b1;
          found_idx = last_idx;
        end else if (cache_v_r && (cached_r < last_idx)) begin
          bnd_re    = 1'b1;
          bnd_addr  = cached_r;
          state_nxt = ST_CACHE_LO;
        end else begin
          start_srch = 1'b1;
        end
      end

      ST_CACHE_LO: begin
        if (item_r.value >= bnd_rdata) begin
          bnd_re    = 1'b1;
          bnd_addr  = cached_r + AW'(1);
          state_nxt = ST_CACHE_HI;
        end else begin
          start_srch = 1'b1;
        end
      end

      ST_CACHE_HI: begin
        if (item_r.value < bnd_rdata) begin
          found     = 1'b1;
          found_idx = cached_r;
        end else begin
          start_srch = 1'b1;
        end
      end

      // one halving step per cycle; next probe issued in the same cycle
      ST_SEARCH: begin
        if (item_r.value < bnd_rdata) begin
          hi_n = mid_r;
        end else begin
          lo_n = mid_r;
        end
        lo_nxt = lo_n;
        hi_nxt = hi_n;
        if (AW'(hi_n - lo_n) > AW'(1)) begin
          sum      = {1'b0, lo_n} + {1'b0, hi_n};
          mid_nxt  = sum[AW:1];
          bnd_re   = 1'b1;
          bnd_addr = sum[AW:1];
        end else begin
          found     = 1'b1;
          found_idx = lo_n;
        end
      end

      ST_COUNT: begin
        hits         = (cnt_rdata == HIT_MAX) ? cnt_rdata : cnt_rdata + HITS_W'(1);
        cnt_we       = 1'b1;
        cnt_addr     = sidx_r;
        cnt_wdata    = hits;
        distinct_nxt = (cnt_rdata == '0) ? distinct_r + DW'(1) : distinct_r;
        cached_nxt   = sidx_r;
        cache_v_nxt  = 1'b1;
        res_nxt                 = '0;
        res_nxt.sample_index    = IDX_W'(sidx_r);
        res_nxt.sample_hits     = hits;
        res_nxt.above_threshold = hits >= cfg.repeat_threshold;
        state_nxt               = ST_EMIT;
      end

      ST_READ: begin
        idx_ok = 32'(item_r.table_index) < 32'(MAX_SAMPLES);
        hits   = idx_ok ? cnt_rdata : '0;
        res_nxt                 = '0;
        res_nxt.sample_index    = item_r.table_index;
        res_nxt.sample_hits     = hits;
        res_nxt.above_threshold = hits >= cfg.repeat_threshold;
        state_nxt               = ST_EMIT;
      end

      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          clr_op_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start_srch) begin
      lo_nxt = '0;
      hi_nxt = last_idx;
      if (last_idx > AW'(1)) begin
        mid_nxt   = last_idx >> 1;
        bnd_re    = 1'b1;
        bnd_addr  = last_idx >> 1;
        state_nxt = ST_SEARCH;
      end else begin
        found     = 1'b1;
        found_idx = '0;
      end
    end

    if (found) begin
      sidx_nxt  = found_idx;
      cnt_re    = 1'b1;
      cnt_addr  = found_idx;
      state_nxt = ST_COUNT;
    end

    if (cfg_inval) begin
      cache_v_nxt = 1'b0;
    end
  end

  always_comb begin
    res_data                = res_r;
    res_data.unique_samples = UNIQ_W'(distinct_r);
  end

endmodule

`default_nettype wire

// ===== sv/occurrence_sample_histogram.sv =====
// Top level of the occurrence sample histogram: configuration registers, output register,
// boundary and count RAMs, sequencer.
// Depends on osh_pkg, osh_ram, osh_ctrl.
`default_nettype none

// Maps occurrence offsets onto a sorted table of sample start offsets and keeps a saturating
// 16-bit hit count per sample plus the number of distinct samples hit. One item is in work
// at a time. A load or an out-of-range offset goes straight to the output register, a read
// does one count RAM read, and an occurrence offset does a boundary RAM read for the
// last-sample test, then if needed up to two boundary reads to check the cached sample, then
// if needed the halving steps of the binary search, one boundary read each and at most
// ceil(log2(samples in use - 1)) of them, then the count RAM read-modify-write and the
// handoff to the output register. A clear zeroes one count entry per cycle. in_ready rises
// in the same cycle as out_valid. After reset the count RAM is swept the same way with
// in_ready low; configuration writes are taken during the sweep. A finished result sits in
// the output register, so the next item can be transferred while it waits.
module occurrence_sample_histogram
  import osh_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_t                 in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_t                     out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_IX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(MAX_SAMPLES);

  cfg_t              cfg_r, cfg_nxt;
  logic              cfg_inval;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              res_valid;
  logic              res_ready;
  out_t              res_data;

  logic              bnd_re, bnd_we;
  logic [AW-1:0]     bnd_addr;
  logic [OFF_W-1:0]  bnd_wdata, bnd_rdata;
  logic              cnt_re, cnt_we;
  logic [AW-1:0]     cnt_addr;
  logic [HITS_W-1:0] cnt_wdata, cnt_rdata;

  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_inval = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_COUNT: begin
          cfg_nxt.sample_count = cfg_wdata[SCNT_W-1:0];
          cfg_inval            = 1'b1;
        end
        REG_STREAM_LENGTH: begin
          cfg_nxt.stream_length = cfg_wdata[OFF_W-1:0];
        end
        REG_REPEAT_THRESHOLD: begin
          cfg_nxt.repeat_threshold = cfg_wdata[HITS_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count     <= SCNT_W'(1);
      cfg_r.stream_length    <= '0;
      cfg_r.repeat_threshold <= HITS_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  osh_ram #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (OFF_W)
  ) u_bnd_ram (
    .clk   (clk),
    .re    (bnd_re),
    .we    (bnd_we),
    .addr  (bnd_addr),
    .wdata (bnd_wdata),
    .rdata (bnd_rdata)
  );

  osh_ram #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (HITS_W)
  ) u_cnt_ram (
    .clk   (clk),
    .re    (cnt_re),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  osh_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_inval (cfg_inval),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .bnd_re    (bnd_re),
    .bnd_we    (bnd_we),
    .bnd_addr  (bnd_addr),
    .bnd_wdata (bnd_wdata),
    .bnd_rdata (bnd_rdata),
    .cnt_re    (cnt_re),
    .cnt_we    (cnt_we),
    .cnt_addr  (cnt_addr),
    .cnt_wdata (cnt_wdata),
    .cnt_rdata (cnt_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/osh_chk.sv =====
// Port-level checker for occurrence_sample_histogram, bound to the top level.
// Depends on osh_pkg.
`default_nettype none

module osh_chk
  import osh_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire in_t                 in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire out_t                out_data
);

  // reset starts the count sweep: nothing taken, nothing shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("input ready or output valid right after reset");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input item dropped or changed");

  a_oor_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |->
      out_data.sample_hits == '0 && !out_data.above_threshold &&
      out_data.sample_index == '0)
    else $error("out-of-range result carries a sample or count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind occurrence_sample_histogram osh_chk u_osh_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/osh_tally_check.sv =====
// Result checker for the occurrence sample histogram: watches the input, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on osh_pkg.
`timescale 1ns / 100ps

module osh_tally_check
  import osh_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_t                 in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_t                out_data,
  input  logic                cfg_wr_en,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output int                  mismatches,
  output int                  pending
);

  logic [OFF_W-1:0]  bounds    [MAX_SAMPLES];
  logic [HITS_W-1:0] hit_tally [MAX_SAMPLES];
  logic [UNIQ_W-1:0] distinct;
  logic [IDX_W-1:0]  cache_idx;
  logic              cache_ok;
  logic [SCNT_W-1:0] sample_cnt;
  logic [OFF_W-1:0]  stream_len;
  logic [HITS_W-1:0] rep_thr;

  out_t pending_results[$];
  int   errors = 0;

  function automatic int samples_used();
    if (sample_cnt == 0) return 1;
    if (int'(sample_cnt) > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(sample_cnt);
  endfunction

  // last-sample test, then the cached sample, then the halving search
  function automatic int find_sample(logic [OFF_W-1:0] off);
    int last;
    int lo;
    int hi;
    int mid;
    int c;
    last = samples_used() - 1;
    c = int'(cache_idx);
    if (off >= bounds[last]) return last;
    if (cache_ok && c < last && off >= bounds[c] && off < bounds[c + 1]) return c;
    lo = 0;
    hi = last;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (off < bounds[mid]) hi = mid;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic out_t tally_item(in_t item);
    out_t r;
    int   s;
    r = '0;
    case (item.operation)
      OP_LOAD: begin
        if (int'(item.table_index) < MAX_SAMPLES) bounds[item.table_index] = item.value;
        cache_ok = 1'b0;
        r.sample_index = item.table_index;
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_SAMPLES; i++) hit_tally[i] = '0;
        distinct  = '0;
        cache_idx = '0;
        cache_ok  = 1'b0;
      end
      OP_OFFSET: begin
        if (item.value > stream_len) begin
          r.out_of_range = 1'b1;
        end else begin
          s = find_sample(item.value);
          cache_idx = IDX_W'(s);
          cache_ok  = 1'b1;
          if (hit_tally[s] == '0) distinct = distinct + UNIQ_W'(1);
          if (hit_tally[s] != HIT_MAX) hit_tally[s] = hit_tally[s] + HITS_W'(1);
          r.sample_index    = IDX_W'(s);
          r.sample_hits     = hit_tally[s];
          r.above_threshold = (hit_tally[s] >= rep_thr);
        end
      end
      OP_READ: begin
        r.sample_index = item.table_index;
        if (int'(item.table_index) < MAX_SAMPLES) r.sample_hits = hit_tally[item.table_index];
        r.above_threshold = (r.sample_hits >= rep_thr);
      end
      default: ;
    endcase
    r.unique_samples = distinct;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SAMPLES; i++) hit_tally[i] = '0;
      distinct   = '0;
      cache_idx  = '0;
      cache_ok   = 1'b0;
      sample_cnt = 11'd1;
      stream_len = '0;
      rep_thr    = 16'd1;
      pending_results.delete();
    end else begin
      // results first, so a stray result is never matched to this cycle's transfer
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: sample_index %0d, sample_hits %0d",
                 out_data.sample_index, out_data.sample_hits);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("sample_index", int'(want.sample_index), int'(out_data.sample_index));
          check_field("sample_hits", int'(want.sample_hits), int'(out_data.sample_hits));
          check_field("above_threshold", int'(want.above_threshold),
                      int'(out_data.above_threshold));
          check_field("unique_samples", int'(want.unique_samples),
                      int'(out_data.unique_samples));
          check_field("out_of_range", int'(want.out_of_range), int'(out_data.out_of_range));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SAMPLE_COUNT: begin
            sample_cnt = cfg_wdata[SCNT_W-1:0];
            cache_ok   = 1'b0;
          end
          REG_STREAM_LENGTH:    stream_len = cfg_wdata[OFF_W-1:0];
          REG_REPEAT_THRESHOLD: rep_thr = cfg_wdata[HITS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_results.push_back(tally_item(in_data));
    end
    mismatches <= errors;
    pending    <= pending_results.size();
  end

endmodule

// ===== sim/occurrence_sample_histogram_tb.sv =====
// Testbench top for the occurrence sample histogram: clock, reset, stimulus and verdict.
// Depends on osh_pkg, occurrence_sample_histogram and osh_tally_check.
`timescale 1ns / 100ps

module occurrence_sample_histogram_tb;
  import osh_pkg::*;

  localparam int MAX_SAMPLES = 1024;
  localparam int STALL_LIMIT = 8000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit gaps_on      = 1'b1;
  bit stalls_on    = 1'b1;

  logic [OFF_W-1:0] boundary_plan [MAX_SAMPLES];

  always #4 clk = ~clk;

  occurrence_sample_histogram #(.MAX_SAMPLES(MAX_SAMPLES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  osh_tally_check #(.MAX_SAMPLES(MAX_SAMPLES)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= idle_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(op_t op, logic [IDX_W-1:0] idx, logic [OFF_W-1:0] val);
    in_t item;
    int  gap;
    item.operation   = op;
    item.table_index = idx;
    item.value       = val;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_registers(logic [SCNT_W-1:0] cnt, logic [OFF_W-1:0] len,
                               logic [HITS_W-1:0] thr);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SAMPLE_COUNT;
    cfg_wdata <= CFG_W'(cnt);
    @(posedge clk);
    cfg_index <= REG_STREAM_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_index <= REG_REPEAT_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic build_table(int n, bit sorted, int spacing);
    for (int i = 0; i < n; i++) begin
      if (!sorted)
        boundary_plan[i] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
      else if (i == 0)
        boundary_plan[i] = $urandom_range(0, 30);
      else
        boundary_plan[i] = boundary_plan[i-1] + $urandom_range(0, spacing);
    end
  endtask

  task automatic random_items(int n, int used, logic [OFF_W-1:0] len, bit sorted);
    int               r;
    int               s;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] last_off;
    last_off = boundary_plan[0];
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send(OP_CLEAR, IDX_W'($urandom), $urandom);
      end else if (r < 12) begin
        // reloads keep a sorted table sorted; entries past the ones in use are free
        if (sorted && used < MAX_SAMPLES && $urandom_range(0, 3) == 0) begin
          s = $urandom_range(used, MAX_SAMPLES - 1);
          boundary_plan[s] = $urandom;
        end else begin
          s = $urandom_range(0, used - 1);
          if (!sorted) boundary_plan[s] = $urandom_range(0, 2000);
        end
        send(OP_LOAD, IDX_W'(s), boundary_plan[s]);
      end else if (r < 24) begin
        s = $urandom_range(0, 1) ? $urandom_range(0, MAX_SAMPLES - 1)
                                 : $urandom_range(0, used - 1);
        send(OP_READ, IDX_W'(s), $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) off = last_off + $urandom_range(0, 3);
        else if (r < 80) off = boundary_plan[$urandom_range(0, used - 1)]
                               + $urandom_range(0, 40);
        else if (r < 88) off = $urandom;
        else if (r < 94) off = len + $urandom_range(0, 1);
        else off = boundary_plan[0] - $urandom_range(0, 2);
        last_off = off;
        send(OP_OFFSET, IDX_W'($urandom), off);
      end
    end
  endtask

  task automatic run_stage(logic [SCNT_W-1:0] cnt, bit full_len, logic [HITS_W-1:0] thr,
                           bit sorted, int spacing, bit fresh, int n);
    int               used;
    logic [OFF_W-1:0] len;
    used = (cnt == 0) ? 1 : ((int'(cnt) > MAX_SAMPLES) ? MAX_SAMPLES : int'(cnt));
    drain();
    gaps_on    = ($urandom_range(0, 3) != 0);
    stalls_on <= ($urandom_range(0, 3) != 0);
    if (fresh) build_table(used, sorted, spacing);
    len = full_len ? '1 : boundary_plan[used-1] + 32'd60;
    set_registers(cnt, len, thr);
    if (fresh)
      for (int i = 0; i < used; i++) send(OP_LOAD, IDX_W'(i), boundary_plan[i]);
    random_items(n, used, len, sorted);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one sample, stream length zero, threshold one
    send(OP_READ, 10'd0, 32'd0);
    send(OP_LOAD, 10'd0, 32'd0);
    send(OP_OFFSET, 10'd0, 32'd0);
    send(OP_OFFSET, 10'h3FF, 32'd1);
    send(OP_OFFSET, 10'd0, 32'hFFFF_FFFF);
    send(OP_LOAD, 10'h3FF, 32'hFFFF_FFFF);
    send(OP_READ, 10'h3FF, 32'hFFFF_FFFF);
    send(OP_CLEAR, 10'h3FF, 32'hFFFF_FFFF);
    send(OP_READ, 10'd0, 32'd0);
    drain();
    // zero count behaves as one sample; threshold zero sets the flag even on empty counts
    set_registers(11'd0, 32'hFFFF_FFFF, 16'd0);
    send(OP_OFFSET, 10'd0, 32'hFFFF_FFFF);
    send(OP_READ, 10'd5, 32'd0);
    drain();
    set_registers(11'd4, 32'd1000, 16'd2);
    for (int i = 0; i < 4; i++) begin
      boundary_plan[i] = OFF_W'((i + 1) * 100);
      send(OP_LOAD, IDX_W'(i), boundary_plan[i]);
    end
    send(OP_OFFSET, 10'd0, 32'd50);     // below the first boundary
    send(OP_OFFSET, 10'd0, 32'd250);
    send(OP_OFFSET, 10'd0, 32'd260);    // same sample again, cached
    send(OP_OFFSET, 10'd0, 32'd400);    // on the last boundary
    send(OP_OFFSET, 10'd0, 32'd1000);   // end of stream still counts
    send(OP_OFFSET, 10'd0, 32'd1001);
    send(OP_READ, 10'd2, 32'd0);
    send(OP_LOAD, 10'd1, 32'd200);      // load drops the cached sample
    send(OP_OFFSET, 10'd0, 32'd260);

    // back-to-back hits on one sample, threshold at the ceiling
    drain();
    gaps_on    = 1'b0;
    stalls_on <= 1'b0;
    set_registers(11'd1, 32'hFFFF_FFFF, 16'hFFFF);
    send(OP_CLEAR, 10'd0, 32'd0);
    send(OP_LOAD, 10'd0, 32'd0);
    repeat (40) send(OP_OFFSET, IDX_W'($urandom), $urandom);
    send(OP_READ, 10'd0, 32'd0);

    run_stage(11'd2, 1'b1, 16'd1, 1'b1, 50, 1'b1, 40);
    run_stage(11'd7, 1'b0, 16'd3, 1'b1, 20, 1'b1, 50);
    run_stage(11'd16, 1'b1, 16'd0, 1'b0, 0, 1'b1, 40);
    run_stage(11'd1024, 1'b1, 16'd2, 1'b1, 64, 1'b1, 100);
    run_stage(11'd2047, 1'b0, 16'hFFFF, 1'b1, 0, 1'b0, 60);
    run_stage(11'd3, 1'b0, 16'd1, 1'b0, 0, 1'b1, 40);
    run_stage(11'd11, 1'b1, 16'd5, 1'b1, 3, 1'b1, 50);
    run_stage(11'd33, 1'b0, 16'd1, 1'b1, 100, 1'b1, 40);
    run_stage(11'd1, 1'b1, 16'd1, 1'b1, 10, 1'b1, 30);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
